// ===== design/pdc8_pkg.sv =====
// Shared types, constants and the CRC-8 step function for the packet deframer.
`timescale 1ns / 1ps

package pdc8_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] SYNC_SECOND = 8'h55;
    localparam logic [7:0] CRC_POLY    = 8'h8C;
    localparam logic [7:0] ACC_FUNC_RESET = 8'd5;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_FUNC,
        PH_LEN,
        PH_DATA,
        PH_CRC
    } t_phase;

    // Work handed from the parser to the output side.
    typedef enum logic [1:0] {
        OP_CRC_FIRST,
        OP_CRC,
        OP_DATA,
        OP_END
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data;
        logic [7:0] idx;
        logic [7:0] func;
        logic [7:0] len;
    } t_entry;

    // One byte of CRC-8/MAXIM, reflected, eight shift steps.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== design/pdc8_front.sv =====
// Frame parser: hunts for sync, tracks header and payload position, issues work entries.
`timescale 1ns / 1ps

module pdc8_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  logic [7:0]       i_s_axis_tdata,   // rx_byte
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output pdc8_pkg::t_entry o_push_entry
);

    pdc8_pkg::t_phase r_phase, n_phase;
    logic [7:0]       r_func, n_func;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_count, n_count;
    logic             w_accept;
    logic [7:0]       w_count_inc;

    assign o_s_axis_tready = i_push_ready;
    assign w_accept        = i_s_axis_tvalid && i_push_ready;
    assign w_count_inc     = r_count + 8'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= pdc8_pkg::PH_HUNT1;
            r_func  <= '0;
            r_len   <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_func  <= n_func;
            r_len   <= n_len;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_phase           = r_phase;
        n_func            = r_func;
        n_len             = r_len;
        n_count           = r_count;
        o_push_valid      = 1'b0;
        o_push_entry.op   = pdc8_pkg::OP_CRC;
        o_push_entry.data = i_s_axis_tdata;
        o_push_entry.idx  = r_count;
        o_push_entry.func = r_func;
        o_push_entry.len  = r_len;
        if (w_accept) begin
            case (r_phase)
                pdc8_pkg::PH_HUNT2: begin
                    n_phase = (i_s_axis_tdata == pdc8_pkg::SYNC_SECOND) ?
                              pdc8_pkg::PH_FUNC : pdc8_pkg::PH_HUNT1;
                end
                pdc8_pkg::PH_FUNC: begin
                    n_func          = i_s_axis_tdata;
                    n_phase         = pdc8_pkg::PH_LEN;
                    o_push_valid    = 1'b1;
                    o_push_entry.op = pdc8_pkg::OP_CRC_FIRST;
                end
                pdc8_pkg::PH_LEN: begin
                    n_len           = i_s_axis_tdata;
                    n_count         = '0;
                    n_phase         = (i_s_axis_tdata == 8'd0) ?
                                      pdc8_pkg::PH_CRC : pdc8_pkg::PH_DATA;
                    o_push_valid    = 1'b1;
                    o_push_entry.op = pdc8_pkg::OP_CRC;
                end
                pdc8_pkg::PH_DATA: begin
                    n_count         = w_count_inc;
                    if (w_count_inc >= r_len) begin
                        n_phase = pdc8_pkg::PH_CRC;
                    end
                    o_push_valid    = 1'b1;
                    o_push_entry.op = pdc8_pkg::OP_DATA;
                end
                pdc8_pkg::PH_CRC: begin
                    n_phase         = pdc8_pkg::PH_HUNT1;
                    o_push_valid    = 1'b1;
                    o_push_entry.op = pdc8_pkg::OP_END;
                end
                default: begin
                    n_phase = (i_s_axis_tdata == pdc8_pkg::SYNC_FIRST) ?
                              pdc8_pkg::PH_HUNT2 : pdc8_pkg::PH_HUNT1;
                end
            endcase
        end
    end

endmodule

// ===== design/pdc8_queue.sv =====
// Small register queue between the parser and the output side.
`timescale 1ns / 1ps

module pdc8_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  pdc8_pkg::t_entry i_push_entry,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output pdc8_pkg::t_entry o_pop_entry
);

    pdc8_pkg::t_entry               r_mem [pdc8_pkg::QDEPTH];
    logic [pdc8_pkg::QAW-1:0]       r_wr_ptr;
    logic [pdc8_pkg::QAW-1:0]       r_rd_ptr;
    logic [pdc8_pkg::QCW-1:0]       r_count;
    logic                           w_push;
    logic                           w_pop;

    assign o_push_ready = (r_count != pdc8_pkg::QCW'(pdc8_pkg::QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + pdc8_pkg::QAW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + pdc8_pkg::QAW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + pdc8_pkg::QCW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - pdc8_pkg::QCW'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pdc8_pkg::QCW'(pdc8_pkg::QDEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_count == $past(r_count) + pdc8_pkg::QCW'(1)))
        else $error("queue count did not rise on push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == pdc8_pkg::QCW'(pdc8_pkg::QDEPTH))
        |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");
`endif

endmodule

// ===== design/pdc8_back.sv =====
// Output side: running CRC, verdict on the trailer byte and the output register.
`timescale 1ns / 1ps

module pdc8_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [7:0]       i_cfg_wdata,
    input  logic             i_pop_valid,
    output logic             o_pop_ready,
    input  pdc8_pkg::t_entry i_pop_entry,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    output logic [1:0]       o_m_axis_tuser
);

    logic [7:0] r_acc_func;
    logic [7:0] r_crc;
    logic       r_out_valid;
    logic [7:0] r_data, r_idx, r_func, r_len;
    logic       r_last, r_ok, r_acc;
    logic       w_crc_only;
    logic       w_pop;
    logic       w_ok;
    logic [7:0] w_crc_in;
    logic [7:0] w_crc_next;

    assign w_crc_only  = (i_pop_entry.op == pdc8_pkg::OP_CRC_FIRST) ||
                         (i_pop_entry.op == pdc8_pkg::OP_CRC);
    assign o_pop_ready = w_crc_only || !r_out_valid || i_m_axis_tready;
    assign w_pop       = i_pop_valid && o_pop_ready;
    assign w_crc_in    = (i_pop_entry.op == pdc8_pkg::OP_CRC_FIRST) ? 8'd0 : r_crc;
    assign w_crc_next  = pdc8_pkg::crc8_update(w_crc_in, i_pop_entry.data);
    assign w_ok        = (i_pop_entry.data == r_crc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_func  <= pdc8_pkg::ACC_FUNC_RESET;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_acc_func <= i_cfg_wdata;
            end
            if (w_pop && (i_pop_entry.op != pdc8_pkg::OP_END)) begin
                r_crc <= w_crc_next;
            end
            if (w_pop && !w_crc_only) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop && !w_crc_only) begin
            r_func <= i_pop_entry.func;
            r_len  <= i_pop_entry.len;
            if (i_pop_entry.op == pdc8_pkg::OP_END) begin
                r_data <= '0;
                r_idx  <= '0;
                r_last <= 1'b1;
                r_ok   <= w_ok;
                r_acc  <= w_ok && (i_pop_entry.func == r_acc_func);
            end else begin
                r_data <= i_pop_entry.data;
                r_idx  <= i_pop_entry.idx;
                r_last <= 1'b0;
                r_ok   <= 1'b0;
                r_acc  <= 1'b0;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_len, r_func, r_idx, r_data};
    assign o_m_axis_tlast  = r_last;
    assign o_m_axis_tuser  = {r_acc, r_ok};

`ifndef SYNTHESIS
    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_last) |-> (r_data == 8'd0 && r_idx == 8'd0))
        else $error("end item carries payload bits");

    a_acc_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_acc) |-> (r_ok && r_last))
        else $error("accepted without a good CRC on an end item");
`endif

endmodule

// ===== design/packet_deframer_crc8.sv =====
// Top level of the sync/header/length frame parser with CRC-8/MAXIM check.
`timescale 1ns / 1ps

// Takes one received byte per request on the slave stream and hunts for the sync
// pair 0xAA 0x55; a byte after 0xAA that is not 0x55 restarts the hunt and is not
// itself taken as a new 0xAA. After sync come a function byte, a length byte, that
// many payload bytes and a CRC-8/MAXIM byte (reflected polynomial 0x8C, initial
// value 0) computed over function, length and payload. Each payload byte leaves as
// a data request as soon as it arrives; the CRC byte produces one end request with
// tlast high, the CRC verdict and the acceptance flag, which is set when the CRC is
// good and the function equals the configured code (reset value 5). Sync and header
// bytes produce no output. The block takes one byte per cycle while its queue has
// room: the parser issues at most one work entry per byte into a four-entry queue,
// and the output side retires one entry per cycle unless the master stalls, so
// a stalled master only stops the input once the queue has filled. A result passes
// the queue write, then the output register. The configuration register is written
// whenever i_cfg_we is high and should only change while no frame is in flight.

module packet_deframer_crc8 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,      // accepted_function
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] payload_byte, [15:8] byte_index, [23:16] function_code, [31:24] frame_length
    output logic [31:0] o_m_axis_tdata,
    output logic        o_m_axis_tlast,   // last
    output logic [1:0]  o_m_axis_tuser    // [0] crc_ok, [1] accepted
);

    logic             w_push_valid;
    logic             w_push_ready;
    pdc8_pkg::t_entry w_push_entry;
    logic             w_pop_valid;
    logic             w_pop_ready;
    pdc8_pkg::t_entry w_pop_entry;

    // Parser: owns the phase, header fields and payload position.
    pdc8_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_push_valid    (w_push_valid),
        .i_push_ready    (w_push_ready),
        .o_push_entry    (w_push_entry)
    );

    // Decoupling queue between parser and output side.
    pdc8_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_entry (w_push_entry),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_entry  (w_pop_entry)
    );

    // Output side: CRC accumulation, verdict and the master-side register.
    pdc8_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_pop_valid     (w_pop_valid),
        .o_pop_ready     (w_pop_ready),
        .i_pop_entry     (w_pop_entry),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the packet deframer with CRC-8/MAXIM trailer check.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_CYCLES = 8;
    localparam int RAND_PER_PHASE = 120;
    localparam int MAX_REPORTS = 40;

    // One result request as seen on the master stream.
    typedef struct {
        logic [7:0] pay_byte;
        logic [7:0] byte_idx;
        logic [7:0] func;
        logic [7:0] len;
        logic       last;
        logic       crc_ok;
        logic       accepted;
    } t_frame_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = 8'h00;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic [1:0]  o_m_axis_tuser;

    packet_deframer_crc8 dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Bytes waiting to be offered on the slave stream, and results still owed
    // by the block, oldest first.
    logic [7:0] rx_backlog[$];
    t_frame_out results_due[$];

    // Shadow of the parser, advanced once per accepted byte.
    pdc8_pkg::t_phase prs_phase = pdc8_pkg::PH_HUNT1;
    logic [7:0] cur_func = 8'h00;
    logic [7:0] cur_len = 8'h00;
    logic [7:0] pay_cnt = 8'h00;
    logic [7:0] crc_acc = 8'h00;
    logic [7:0] acc_func = pdc8_pkg::ACC_FUNC_RESET;

    int errors = 0;
    int rx_pushed = 0;
    int rx_accepted = 0;
    int cycles = 0;
    int tx_gap_max = 0;
    int rx_stall_max = 0;
    int holds_asked = 0;
    int holds_done = 0;
    int data_seen = 0;
    int ends_seen = 0;
    int acc_seen = 0;
    int bad_seen = 0;

    // Bit-serial form of the reflected CRC-8: each input bit, lowest first, is
    // mixed with the register's low bit to decide whether the polynomial folds in.
    function automatic logic [7:0] crc8_maxim_step(logic [7:0] crc, logic [7:0] b);
        logic [7:0] r;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            if (r[0] ^ b[i]) begin
                r = (r >> 1) ^ pdc8_pkg::CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // Advances the parser shadow by one received byte and records the result it owes.
    function automatic void deframe_predict(logic [7:0] b);
        t_frame_out r;
        r.pay_byte = 8'h00;
        r.byte_idx = 8'h00;
        r.last = 1'b0;
        r.crc_ok = 1'b0;
        r.accepted = 1'b0;
        case (prs_phase)
            pdc8_pkg::PH_HUNT2: begin
                if (b == pdc8_pkg::SYNC_SECOND) begin
                    prs_phase = pdc8_pkg::PH_FUNC;
                end else begin
                    prs_phase = pdc8_pkg::PH_HUNT1;
                end
            end
            pdc8_pkg::PH_FUNC: begin
                cur_func = b;
                crc_acc = crc8_maxim_step(8'h00, b);
                prs_phase = pdc8_pkg::PH_LEN;
            end
            pdc8_pkg::PH_LEN: begin
                cur_len = b;
                pay_cnt = 8'h00;
                crc_acc = crc8_maxim_step(crc_acc, b);
                if (b == 8'h00) begin
                    prs_phase = pdc8_pkg::PH_CRC;
                end else begin
                    prs_phase = pdc8_pkg::PH_DATA;
                end
            end
            pdc8_pkg::PH_DATA: begin
                r.pay_byte = b;
                r.byte_idx = pay_cnt;
                r.func = cur_func;
                r.len = cur_len;
                crc_acc = crc8_maxim_step(crc_acc, b);
                pay_cnt = pay_cnt + 8'd1;
                if (pay_cnt >= cur_len) begin
                    prs_phase = pdc8_pkg::PH_CRC;
                end
                results_due.insert(results_due.size(), r);
            end
            pdc8_pkg::PH_CRC: begin
                r.func = cur_func;
                r.len = cur_len;
                r.last = 1'b1;
                r.crc_ok = (b == crc_acc);
                r.accepted = r.crc_ok && (cur_func == acc_func);
                prs_phase = pdc8_pkg::PH_HUNT1;
                results_due.insert(results_due.size(), r);
            end
            default: begin
                if (b == pdc8_pkg::SYNC_FIRST) begin
                    prs_phase = pdc8_pkg::PH_HUNT2;
                end else begin
                    prs_phase = pdc8_pkg::PH_HUNT1;
                end
            end
        endcase
    endfunction

    function automatic void check_field(string what, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %02h, actual %02h", $time, what, want, got);
            end
        end
    endfunction

    // Driver: offers the backlog one byte at a time, with a random gap after
    // each byte. The shadow parser advances on every accepted request.
    always @(posedge i_clk) begin
        logic       offer;
        logic [7:0] byte_q;
        int         tx_gap;
        offer = s_valid;
        byte_q = s_data;
        if (!i_rst_n) begin
            offer = 1'b0;
            tx_gap = 0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                deframe_predict(s_data);
                rx_accepted++;
                offer = 1'b0;
            end
            if (!offer) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (rx_backlog.size() > 0) begin
                    byte_q = rx_backlog.pop_front();
                    offer = 1'b1;
                    tx_gap = $urandom_range(0, tx_gap_max);
                end
            end
        end
        s_valid <= offer;
        s_data <= byte_q;
    end

    // Monitor: takes results, checks each against the oldest one owed, and
    // stalls the master stream for a random stretch after every result. A long
    // hold, when asked for, is counted down here as well.
    always @(posedge i_clk) begin
        logic       rdy;
        t_frame_out got;
        t_frame_out want;
        int         rx_stall;
        int         hold_left;
        rdy = 1'b0;
        if (!i_rst_n) begin
            rx_stall = 0;
            hold_left = 0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                got.pay_byte = o_m_axis_tdata[7:0];
                got.byte_idx = o_m_axis_tdata[15:8];
                got.func = o_m_axis_tdata[23:16];
                got.len = o_m_axis_tdata[31:24];
                got.last = o_m_axis_tlast;
                got.crc_ok = o_m_axis_tuser[0];
                got.accepted = o_m_axis_tuser[1];
                if (results_due.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS) begin
                        $display("%0t: unexpected result, expected none, %s %08h last %b user %b",
                                 $time, "actual", o_m_axis_tdata, o_m_axis_tlast,
                                 o_m_axis_tuser);
                    end
                end else begin
                    want = results_due.pop_front();
                    check_field("payload_byte", want.pay_byte, got.pay_byte);
                    check_field("byte_index", want.byte_idx, got.byte_idx);
                    check_field("function_code", want.func, got.func);
                    check_field("frame_length", want.len, got.len);
                    check_field("last", {7'b0, want.last}, {7'b0, got.last});
                    check_field("crc_ok", {7'b0, want.crc_ok}, {7'b0, got.crc_ok});
                    check_field("accepted", {7'b0, want.accepted}, {7'b0, got.accepted});
                end
                if (got.last) begin
                    ends_seen++;
                    if (got.accepted) acc_seen++;
                    if (!got.crc_ok) bad_seen++;
                end else begin
                    data_seen++;
                end
                rx_stall = $urandom_range(0, rx_stall_max);
            end
            if (holds_done != holds_asked) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
            end else if (rx_stall > 0) begin
                rx_stall--;
            end else begin
                rdy = 1'b1;
            end
        end
        m_ready <= rdy;
    end

    // Watchdog for a block that hangs or never delivers.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic queue_rx_byte(logic [7:0] b);
        rx_backlog.insert(rx_backlog.size(), b);
        rx_pushed++;
    endtask

    // Queues sync, header, payload and trailer. A frame cut short stops after
    // 'keep' payload bytes and leaves its trailer out; a corrupt one gets a bad CRC.
    task automatic queue_frame(logic [7:0] func, int len, bit corrupt, int keep);
        logic [7:0] crc;
        logic [7:0] b;
        queue_rx_byte(pdc8_pkg::SYNC_FIRST);
        queue_rx_byte(pdc8_pkg::SYNC_SECOND);
        queue_rx_byte(func);
        queue_rx_byte(len[7:0]);
        crc = crc8_maxim_step(crc8_maxim_step(8'h00, func), len[7:0]);
        for (int i = 0; i < len; i++) begin
            if (i >= keep) return;
            b = $urandom_range(0, 255);
            crc = crc8_maxim_step(crc, b);
            queue_rx_byte(b);
        end
        if (corrupt) begin
            crc = crc ^ 8'($urandom_range(1, 255));
        end
        queue_rx_byte(crc);
    endtask

    // Waits until every byte is taken and every owed result has arrived, then
    // lets the pipeline run empty.
    task automatic wait_link_quiet();
        for (int k = 0; k < 40000; k++) begin
            if (rx_accepted == rx_pushed && results_due.size() == 0) break;
            @(posedge i_clk);
        end
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Feeds filler bytes until the parser is back at the hunt, so that no
    // frame is open when the register changes.
    task automatic flush_open_frame();
        while (prs_phase != pdc8_pkg::PH_HUNT1) begin
            queue_rx_byte(8'h00);
            while (rx_accepted != rx_pushed) @(posedge i_clk);
        end
        wait_link_quiet();
    endtask

    task automatic set_accepted_function(logic [7:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        acc_func = v;
    endtask

    initial begin
        int         made;
        int         pick;
        int         len;
        int         n;
        logic [7:0] cfg_now;
        logic [7:0] func;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, with the register at its reset value.
        tx_gap_max = 3;
        rx_stall_max = 3;
        queue_rx_byte(8'h00);
        queue_rx_byte(8'hFF);
        // A second 0xAA after a first one breaks the sync and is not taken as
        // a new start, so the 0x55 behind it is just noise.
        queue_rx_byte(pdc8_pkg::SYNC_FIRST);
        queue_rx_byte(pdc8_pkg::SYNC_FIRST);
        queue_rx_byte(pdc8_pkg::SYNC_SECOND);
        queue_rx_byte(8'h00);
        // Empty payload with a good trailer and the accepted function.
        queue_frame(pdc8_pkg::ACC_FUNC_RESET, 0, 1'b0, 0);
        // Accepted function but a bad trailer: crc_ok and accepted both drop.
        queue_frame(pdc8_pkg::ACC_FUNC_RESET, 2, 1'b1, 2);
        // Good trailer on a function that is not accepted; a sync byte inside
        // the payload must not restart the parser.
        queue_rx_byte(pdc8_pkg::SYNC_FIRST);
        queue_rx_byte(pdc8_pkg::SYNC_SECOND);
        queue_rx_byte(8'hFF);
        queue_rx_byte(8'h01);
        queue_rx_byte(pdc8_pkg::SYNC_FIRST);
        queue_rx_byte(crc8_maxim_step(crc8_maxim_step(crc8_maxim_step(8'h00, 8'hFF),
                                                      8'h01), pdc8_pkg::SYNC_FIRST));
        wait_link_quiet();

        // Random part in five settings of the register and of the idling.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: cfg_now = pdc8_pkg::ACC_FUNC_RESET;
                1: cfg_now = 8'h00;
                2: cfg_now = 8'hFF;
                3: cfg_now = 8'($urandom_range(1, 254));
                default: cfg_now = pdc8_pkg::ACC_FUNC_RESET;
            endcase
            if (phase > 0) set_accepted_function(cfg_now);
            case (phase)
                0: begin tx_gap_max = 19; rx_stall_max = 19; end
                1: begin tx_gap_max = 0;  rx_stall_max = 0;  end
                2: begin tx_gap_max = 0;  rx_stall_max = 19; end
                3: begin tx_gap_max = 19; rx_stall_max = 0;  end
                default: begin tx_gap_max = 7; rx_stall_max = 7; end
            endcase
            // The sender keeps offering at full rate while the receiver holds
            // off, so the block's queue fills and its input stalls.
            if (phase == 2) holds_asked++;
            // One frame of the largest size reaches the top byte indexes.
            if (phase == 3) begin
                queue_frame(8'($urandom_range(0, 255)), 255, 1'b0, 255);
            end
            made = 0;
            while (made < RAND_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 1) == 1) begin
                    func = cfg_now;
                end else begin
                    func = 8'($urandom_range(0, 255));
                end
                if ($urandom_range(0, 9) == 0) begin
                    len = $urandom_range(9, 40);
                end else begin
                    len = $urandom_range(0, 8);
                end
                if (pick < 65) begin
                    queue_frame(func, len, 1'b0, len);
                    made += len + 5;
                end else if (pick < 77) begin
                    queue_frame(func, len, 1'b1, len);
                    made += len + 5;
                end else if (pick < 85) begin
                    // Frame cut short; whatever follows is taken as its tail.
                    n = (len == 0) ? 0 : $urandom_range(0, len - 1);
                    queue_frame(func, len, 1'b0, n);
                    made += n + 4;
                end else if (pick < 93) begin
                    queue_rx_byte(pdc8_pkg::SYNC_FIRST);
                    queue_rx_byte(($urandom_range(0, 3) == 0) ?
                                  pdc8_pkg::SYNC_FIRST : 8'($urandom_range(0, 255)));
                end else begin
                    n = $urandom_range(1, 4);
                    for (int i = 0; i < n; i++) queue_rx_byte(8'($urandom_range(0, 255)));
                end
            end
            wait_link_quiet();
            flush_open_frame();
        end

        wait_link_quiet();
        if (results_due.size() != 0) begin
            errors += results_due.size();
            $display("%0t: %0d results still owed at the end, expected none",
                     $time, results_due.size());
        end
        $display("Sent %0d bytes under five register settings; checked %0d payload results",
                 rx_accepted, data_seen);
        $display("and %0d frame ends (%0d accepted, %0d with a bad CRC), %0d mismatches.",
                 ends_seen, acc_seen, bad_seen, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/pdc8_pkg.sv
design/pdc8_front.sv
design/pdc8_queue.sv
design/pdc8_back.sv
design/packet_deframer_crc8.sv
tb/sv/testbench.sv
